>>> src/framed_can_envelope_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Framed CAN envelope deframer: assertion macros
// Shared concurrent assertion macros. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAMED_CAN_ENVELOPE_DEFRAMER_UNIT_MACROS_SVH
`define FRAMED_CAN_ENVELOPE_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FCDU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcdu: implication check failed");
// The expression must never be true out of reset.
`define FCDU_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fcdu: forbidden condition seen");
`else
`define FCDU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FCDU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> src/fcdu_pkg.sv
// ----------------------------------------------------------------------------
// fcdu_pkg
// Constants and controller/datapath interface types of the envelope deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcdu_pkg;

    // Header bytes that open every envelope.
    localparam logic [7:0] HDR_CA = 8'hCA;
    localparam logic [7:0] HDR_FD = 8'hFD;

    // Identifier bytes after the header, and bytes fed back on a rejected header.
    localparam int unsigned ID_BYTES     = 4;
    localparam int unsigned REPLAY_STEPS = 5;

    // Longest payload of a classic frame; longer ones need the flexible format.
    localparam int unsigned CLASSIC_LEN = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic feed_replay;    // compare/shift the replay byte instead of the input
        logic id_clear;
        logic id_shift;
        logic cnt_clear;
        logic cnt_inc;
        logic len_load;
        logic replay_load;
        logic replay_shift;
        logic mem_write;
        logic idx_clear;
        logic idx_inc;
        logic rd_issue;
        logic out_load_data;
        logic out_load_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic feed_is_ca;
        logic feed_is_fd;
        logic len_over;
        logic len_zero;
        logic id_done;
        logic pay_done;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> src/fcdu_ctrl.sv
// ----------------------------------------------------------------------------
// fcdu_ctrl
// Parser and sequencer state machine: header hunt, identifier, length and
// payload gathering, header rescan on a bad length, and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "framed_can_envelope_deframer_unit_macros.svh"

module fcdu_ctrl
    import fcdu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_GOT_CA,
        PH_ID,
        PH_LEN,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_REPLAY,
        ST_EMPTY,
        ST_RD,
        ST_LD
    } t_state;

    localparam logic [2:0] REPLAY_LAST = 3'(REPLAY_STEPS - 1);

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [2:0] r_rcnt, n_rcnt;
    logic       w_acc;
    logic       w_feed;

    // Input bytes are taken only while the parser runs.
    assign o_in_stall = (r_state != ST_RUN);
    assign w_acc      = i_in_valid && (r_state == ST_RUN);

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_rcnt  = r_rcnt;
        o_cmd   = '0;
        w_feed  = 1'b0;

        unique case (r_state)
            ST_RUN: begin
                if (w_acc) begin
                    unique case (r_phase)
                        PH_LEN: begin
                            o_cmd.cnt_clear = 1'b1;
                            if (i_sts.len_over) begin
                                // Bad length: rescan the identifier and length bytes.
                                o_cmd.replay_load = 1'b1;
                                n_phase           = PH_HUNT;
                                n_rcnt            = '0;
                                n_state           = ST_REPLAY;
                            end else begin
                                o_cmd.len_load = 1'b1;
                                if (i_sts.len_zero) begin
                                    n_phase = PH_HUNT;
                                    n_state = ST_EMPTY;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            o_cmd.mem_write = 1'b1;
                            o_cmd.cnt_inc   = 1'b1;
                            if (i_sts.pay_done) begin
                                o_cmd.cnt_inc   = 1'b0;
                                o_cmd.cnt_clear = 1'b1;
                                o_cmd.idx_clear = 1'b1;
                                n_phase         = PH_HUNT;
                                n_state         = ST_RD;
                            end
                        end
                        default: begin
                            w_feed = 1'b1;
                        end
                    endcase
                end
            end
            ST_REPLAY: begin
                w_feed             = 1'b1;
                o_cmd.feed_replay  = 1'b1;
                o_cmd.replay_shift = 1'b1;
                n_rcnt             = r_rcnt + 3'd1;
                if (r_rcnt == REPLAY_LAST) begin
                    n_rcnt  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_empty = 1'b1;
                    n_state              = ST_RUN;
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_LD;
            end
            ST_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_data = 1'b1;
                    o_cmd.idx_inc       = 1'b1;
                    n_state             = i_sts.emit_last ? ST_RUN : ST_RD;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        // One header hunt or identifier step, from the input byte or the replay byte.
        if (w_feed) begin
            unique case (r_phase)
                PH_GOT_CA: begin
                    if (i_sts.feed_is_fd) begin
                        n_phase         = PH_ID;
                        o_cmd.id_clear  = 1'b1;
                        o_cmd.cnt_clear = 1'b1;
                    end else if (!i_sts.feed_is_ca) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_ID: begin
                    o_cmd.id_shift = 1'b1;
                    if (i_sts.id_done) begin
                        o_cmd.cnt_clear = 1'b1;
                        n_phase         = PH_LEN;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
                default: begin
                    n_phase = i_sts.feed_is_ca ? PH_GOT_CA : PH_HUNT;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_phase <= PH_HUNT;
            r_rcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_rcnt  <= n_rcnt;
        end
    end

    // A rescan holds at most three identifier bytes, so it never reaches a length.
    `FCDU_ASSERT_IMPLY(a_replay_no_len, i_clk, i_rst_n, r_state == ST_REPLAY, r_phase == PH_HUNT || r_phase == PH_GOT_CA || r_phase == PH_ID)
    `FCDU_ASSERT_NEVER(a_replay_cnt_range, i_clk, i_rst_n, r_rcnt > REPLAY_LAST)
    `FCDU_ASSERT_IMPLY(a_empty_hunts, i_clk, i_rst_n, r_state == ST_EMPTY || r_state == ST_RD || r_state == ST_LD, r_phase == PH_HUNT)

endmodule

`default_nettype wire

>>> src/fcdu_datapath.sv
// ----------------------------------------------------------------------------
// fcdu_datapath
// Identifier, length and counters, rescan shift register, payload memory and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "framed_can_envelope_deframer_unit_macros.svh"

module fcdu_datapath
    import fcdu_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_in_byte,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic [31:0]      o_can_id,
    output logic [6:0]       o_frame_size,
    output logic [5:0]       o_byte_index,
    output logic [7:0]       o_data_byte,
    output logic             o_byte_present,
    output logic             o_needs_fd,
    output logic             o_last
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [31:0]   r_id;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [39:0]   r_rep;
    logic [7:0]    r_mem [MAX_PAYLOAD];
    logic [7:0]    r_rd_data;
    logic [7:0]    w_feed;
    logic [7:0]    w_len8;
    logic [7:0]    w_idx8;
    logic          w_out_load;

    logic          r_valid;
    logic [31:0]   r_o_id;
    logic [6:0]    r_o_len;
    logic [5:0]    r_o_idx;
    logic [7:0]    r_o_data;
    logic          r_o_present;
    logic          r_o_fd;
    logic          r_o_last;

    // Byte under test: the received byte, or the head of the rescan register.
    assign w_feed = i_cmd.feed_replay ? r_rep[39:32] : i_in_byte;
    assign w_len8 = 8'(r_len);
    assign w_idx8 = 8'(r_idx);

    // Any load of the output register.
    assign w_out_load = i_cmd.out_load_data || i_cmd.out_load_empty;

    // Status toward the controller.
    always_comb begin
        o_sts.feed_is_ca = (w_feed == HDR_CA);
        o_sts.feed_is_fd = (w_feed == HDR_FD);
        o_sts.len_over   = (i_in_byte > MAX_LEN);
        o_sts.len_zero   = (i_in_byte == 8'd0);
        o_sts.id_done    = (r_cnt == CW'(ID_BYTES - 1));
        o_sts.pay_done   = (({1'b0, r_cnt} + (CW + 1)'(1)) >= {1'b0, r_len});
        o_sts.emit_last  = (({1'b0, r_idx} + (CW + 1)'(1)) == {1'b0, r_len});
        o_sts.out_free   = !r_valid || !i_out_stall;
    end

    // Counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.cnt_clear) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    // Identifier, length and rescan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= '0;
            r_len <= '0;
        end else begin
            if (i_cmd.id_clear) begin
                r_id <= '0;
            end else if (i_cmd.id_shift) begin
                r_id <= {r_id[23:0], w_feed};
            end
            if (i_cmd.len_load) begin
                r_len <= CW'(i_in_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.replay_load) begin
            r_rep <= {r_id, i_in_byte};
        end else if (i_cmd.replay_shift) begin
            r_rep <= {r_rep[31:0], 8'd0};
        end
    end

    // Payload memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[r_cnt[AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load_data || i_cmd.out_load_empty) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_data || i_cmd.out_load_empty) begin
            r_o_id      <= r_id;
            r_o_len     <= w_len8[6:0];
            r_o_fd      <= (w_len8 > 8'(CLASSIC_LEN));
            r_o_idx     <= i_cmd.out_load_data ? w_idx8[5:0] : 6'd0;
            r_o_data    <= i_cmd.out_load_data ? r_rd_data : 8'd0;
            r_o_present <= i_cmd.out_load_data;
            r_o_last    <= i_cmd.out_load_empty || o_sts.emit_last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_can_id       = r_o_id;
    assign o_frame_size   = r_o_len;
    assign o_byte_index   = r_o_idx;
    assign o_data_byte    = r_o_data;
    assign o_byte_present = r_o_present;
    assign o_needs_fd     = r_o_fd;
    assign o_last         = r_o_last;

    // A waiting result is never overwritten.
    `FCDU_ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, w_out_load, !r_valid || !i_out_stall)
    // Payload writes stay inside the memory.
    `FCDU_ASSERT_IMPLY(a_write_in_range, i_clk, i_rst_n, i_cmd.mem_write, r_cnt < CW'(MAX_PAYLOAD))
    // Identifier gathering stops after four bytes.
    `FCDU_ASSERT_IMPLY(a_id_count, i_clk, i_rst_n, i_cmd.id_shift, r_cnt < CW'(ID_BYTES))

endmodule

`default_nettype wire

>>> src/framed_can_envelope_deframer_unit.sv
// ----------------------------------------------------------------------------
// framed_can_envelope_deframer_unit
// Hunts for the 0xCA 0xFD header in a byte stream, gathers identifier, length
// and payload, and emits one result per payload byte of each valid frame.
//
// Input channel: one stream byte per transfer (i_in_valid / o_in_stall).
// Output channel: one result per transfer (o_out_valid / i_out_stall).
// Header, identifier, length and payload bytes are taken with no input
// stall. A length above MAX_PAYLOAD stalls the input while the identifier
// and length bytes are rescanned for a new header. After the last payload
// byte the input stalls while results go out one at a time, each by a
// memory read and then an output register load. An empty frame gives one
// result after its length byte, with no memory read. A stalled result holds
// in the output register; while it waits the block keeps taking header and
// payload bytes, and stops only when the next result is due. Reset returns
// the parser to the header hunt and drops any pending result; the payload
// memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_can_envelope_deframer_unit
    import fcdu_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_can_id,
    output logic [6:0]       o_frame_size,
    output logic [5:0]       o_byte_index,
    output logic [7:0]       o_data_byte,
    output logic             o_byte_present,
    output logic             o_needs_fd,
    output logic             o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Controller.
    fcdu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    fcdu_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_can_id       (o_can_id),
        .o_frame_size   (o_frame_size),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte),
        .o_byte_present (o_byte_present),
        .o_needs_fd     (o_needs_fd),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_framed_can_envelope_deframer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the framed CAN envelope deframer
// Streams header, identifier, length and payload bytes into the block and
// predicts every result it must emit. Results are checked field by field in
// order. Directed cases cover header hunting, length rejection with rescan,
// and empty frames. Random frames then run under three sender and receiver
// idle mixes.
// ----------------------------------------------------------------------------

module tb_framed_can_envelope_deframer_unit;
    import fcdu_pkg::*;

    localparam int MAX_PAYLOAD_LEN = 64;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        HUNT_CA,
        WAIT_FD,
        GATHER_ID,
        WAIT_LEN,
        GATHER_PAYLOAD
    } t_parse_phase;

    typedef struct packed {
        logic [31:0] can_id;
        logic [6:0]  frame_size;
        logic [5:0]  byte_index;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        needs_fd;
        logic        is_last;
    } t_frame_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_can_id;
    logic [6:0]  o_frame_size;
    logic [5:0]  o_byte_index;
    logic [7:0]  o_data_byte;
    logic        o_byte_present;
    logic        o_needs_fd;
    logic        o_last;

    // Predictor state.
    t_parse_phase  phase;
    logic [31:0]   gathered_id;
    logic [6:0]    frame_len;
    int unsigned   byte_count;
    logic [7:0]    payload_copy [0:MAX_PAYLOAD_LEN-1];
    t_frame_result expected_results [$];

    // Run statistics and failure bookkeeping.
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int bytes_sent        = 0;
    int results_checked   = 0;
    int frames_done       = 0;
    int empty_frames      = 0;
    int full_frames       = 0;
    int rejected_headers  = 0;
    int failures          = 0;
    int idle_cycles       = 0;

    framed_can_envelope_deframer_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_can_id      (o_can_id),
        .o_frame_size  (o_frame_size),
        .o_byte_index  (o_byte_index),
        .o_data_byte   (o_data_byte),
        .o_byte_present(o_byte_present),
        .o_needs_fd    (o_needs_fd),
        .o_last        (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Header hunt and identifier gathering, shared by live bytes and the rescan.
    function automatic void feed_header_hunt(input logic [7:0] b);
        case (phase)
            WAIT_FD: begin
                if (b == HDR_FD) begin
                    phase       = GATHER_ID;
                    byte_count  = 0;
                    gathered_id = '0;
                end else if (b != HDR_CA) begin
                    phase = HUNT_CA;
                end
            end
            GATHER_ID: begin
                gathered_id = {gathered_id[23:0], b};
                byte_count++;
                if (byte_count >= ID_BYTES) begin
                    phase      = WAIT_LEN;
                    byte_count = 0;
                end
            end
            default: begin
                phase = (b == HDR_CA) ? WAIT_FD : HUNT_CA;
            end
        endcase
    endfunction

    function automatic void queue_result(input int unsigned idx, input logic [7:0] data,
                                         input logic present, input logic is_last);
        t_frame_result r;
        r.can_id       = gathered_id;
        r.frame_size   = frame_len;
        r.byte_index   = idx[5:0];
        r.data_byte    = data;
        r.byte_present = present;
        r.needs_fd     = (frame_len > CLASSIC_LEN);
        r.is_last      = is_last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Advances the predicted parser by one accepted byte and queues its results.
    function automatic void predict_byte(input logic [7:0] b);
        logic [31:0] saved_id;
        logic [7:0]  replay_byte;
        int unsigned k;
        case (phase)
            WAIT_LEN: begin
                if (b > MAX_PAYLOAD_LEN) begin
                    // Rejected header: the identifier and length bytes are rescanned.
                    saved_id   = gathered_id;
                    phase      = HUNT_CA;
                    byte_count = 0;
                    rejected_headers++;
                    for (k = 0; k < REPLAY_STEPS; k++) begin
                        replay_byte = (k < ID_BYTES) ? 8'(saved_id >> (24 - 8 * k)) : b;
                        feed_header_hunt(replay_byte);
                    end
                end else begin
                    frame_len  = b[6:0];
                    byte_count = 0;
                    if (b == 8'h00) begin
                        queue_result(0, 8'h00, 1'b0, 1'b1);
                        frames_done++;
                        empty_frames++;
                        phase = HUNT_CA;
                    end else begin
                        phase = GATHER_PAYLOAD;
                    end
                end
            end
            GATHER_PAYLOAD: begin
                if (byte_count < MAX_PAYLOAD_LEN) begin
                    payload_copy[byte_count] = b;
                end
                byte_count++;
                if (byte_count >= frame_len) begin
                    for (k = 0; k < frame_len; k++) begin
                        queue_result(k, payload_copy[k], 1'b1, (k + 1 == frame_len));
                    end
                    frames_done++;
                    if (frame_len == MAX_PAYLOAD_LEN) begin
                        full_frames++;
                    end
                    phase      = HUNT_CA;
                    byte_count = 0;
                end
            end
            default: begin
                feed_header_hunt(b);
            end
        endcase
    endfunction

    // Receiver side: random stall at the current idle rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Every result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got.can_id       = o_can_id;
            got.frame_size   = o_frame_size;
            got.byte_index   = o_byte_index;
            got.data_byte    = o_data_byte;
            got.byte_present = o_byte_present;
            got.needs_fd     = o_needs_fd;
            got.is_last      = o_last;
            results_checked++;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: unexpected result id=%h len=%0d idx=%0d data=%h",
                             $realtime, got.can_id, got.frame_size, got.byte_index,
                             got.data_byte);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.can_id !== want.can_id ||
                    got.frame_size !== want.frame_size ||
                    got.byte_index !== want.byte_index ||
                    got.data_byte !== want.data_byte ||
                    got.byte_present !== want.byte_present ||
                    got.needs_fd !== want.needs_fd ||
                    got.is_last !== want.is_last) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display({"%0t: mismatch exp id=%h len=%0d idx=%0d data=%h",
                                  " pres=%b fd=%b last=%b"},
                                 $realtime, want.can_id, want.frame_size, want.byte_index,
                                 want.data_byte, want.byte_present, want.needs_fd,
                                 want.is_last);
                        $display({"%0t:          got id=%h len=%0d idx=%0d data=%h",
                                  " pres=%b fd=%b last=%b"},
                                 $realtime, got.can_id, got.frame_size, got.byte_index,
                                 got.data_byte, got.byte_present, got.needs_fd, got.is_last);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding.",
                         expected_results.size());
                $display("tb_framed_can_envelope_deframer_unit: errors");
                $finish;
            end
        end
    end

    // Sends one byte, with random idle cycles ahead of it, and predicts it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_sequence(input logic [7:0] seq [$]);
        foreach (seq[i]) begin
            send_byte(seq[i]);
        end
    endtask

    // Holds the input idle until every queued result has come out.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Stream byte biased toward the header values.
    function automatic logic [7:0] pick_stream_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) begin
            return HDR_CA;
        end else if (r == 1) begin
            return HDR_FD;
        end
        return 8'($urandom_range(255));
    endfunction

    // Mostly short frames, some medium, a few at the maximum.
    function automatic int pick_frame_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(12);
        end else if (r < 96) begin
            return $urandom_range(63, 13);
        end
        return MAX_PAYLOAD_LEN;
    endfunction

    task automatic send_good_frame(input int len);
        int i;
        send_byte(HDR_CA);
        send_byte(HDR_FD);
        for (i = 0; i < ID_BYTES; i++) begin
            send_byte(pick_stream_byte());
        end
        send_byte(8'(len));
        for (i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // Header with an oversized length, sometimes hiding a new header in its identifier.
    task automatic send_rejected_header();
        logic [7:0]  id_bytes [0:3];
        int unsigned pos;
        int unsigned r;
        int          i;
        for (i = 0; i < ID_BYTES; i++) begin
            id_bytes[i] = pick_stream_byte();
        end
        if ($urandom_range(2) == 0) begin
            pos               = $urandom_range(2);
            id_bytes[pos]     = HDR_CA;
            id_bytes[pos + 1] = HDR_FD;
        end
        send_byte(HDR_CA);
        send_byte(HDR_FD);
        for (i = 0; i < ID_BYTES; i++) begin
            send_byte(id_bytes[i]);
        end
        r = $urandom_range(3);
        if (r == 0) begin
            send_byte(8'(MAX_PAYLOAD_LEN + 1));
        end else if (r == 1) begin
            send_byte(8'hFF);
        end else begin
            send_byte(8'($urandom_range(254, MAX_PAYLOAD_LEN + 2)));
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) send_byte(pick_stream_byte());
    endtask

    // Repeated 0xCA, a full-scale identifier, and a broken header.
    task automatic test_header_hunt();
        send_sequence('{HDR_CA, HDR_CA, HDR_FD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02,
                        8'h00, 8'hFF, HDR_CA, 8'h00, HDR_FD});
    endtask

    // Oversized lengths with a header found in the rescan, then an empty frame.
    task automatic test_length_checks();
        send_sequence('{HDR_CA, HDR_FD, HDR_CA, HDR_FD, 8'h01, 8'h02, 8'hFF, 8'h41,
                        8'h41, HDR_CA, HDR_FD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    // Random mix of good frames, rejected headers and noise at one idle setting.
    task automatic test_random_frames(input int item_target, input int snd_pct,
                                      input int rcv_pct);
        int first_byte;
        int unsigned kind;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        hold_until_drained();
        first_byte = bytes_sent;
        send_good_frame(MAX_PAYLOAD_LEN);
        while (bytes_sent - first_byte < item_target) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                send_good_frame(pick_frame_length());
            end else if (kind < 87) begin
                send_rejected_header();
            end else begin
                send_noise();
            end
            if ($urandom_range(19) == 0) begin
                hold_until_drained();
            end
        end
    endtask

    initial begin
        phase       = HUNT_CA;
        gathered_id = '0;
        frame_len   = '0;
        byte_count  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 36;
        receiver_idle_pct = 50;
        test_header_hunt();
        test_length_checks();
        test_random_frames(140, 36, 50);
        test_random_frames(140, 50, 36);
        test_random_frames(140, 0, 0);

        // Let the last results drain, then allow a few quiet cycles.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            failures += expected_results.size();
            $display("%0d expected results never arrived.", expected_results.size());
        end

        $display("Run: %0d bytes in, %0d results checked, %0d frames (%0d empty, %0d full).",
                 bytes_sent, results_checked, frames_done, empty_frames, full_frames);
        $display("Run: %0d headers rejected for length, %0d failures.",
                 rejected_headers, failures);
        if (failures == 0) begin
            $display("tb_framed_can_envelope_deframer_unit: clean");
        end else begin
            $display("tb_framed_can_envelope_deframer_unit: errors");
        end
        $finish;
    end

endmodule

>>> framed_can_envelope_deframer_unit.f
+incdir+src
src/fcdu_pkg.sv
src/fcdu_ctrl.sv
src/fcdu_datapath.sv
src/framed_can_envelope_deframer_unit.sv
tb/sv/tb_framed_can_envelope_deframer_unit.sv
